// ----- design/sitd_pkg.sv -----
// Shared constants and types for the signed integer to decimal text converter.
`timescale 1ns / 1ps

package sitd_pkg;

    localparam int VALUE_W    = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    // Converted number handed from the BCD converter to the character emitter.
    typedef struct packed {
        logic             negative;
        logic [BCD_W-1:0] bcd;
    } bcd_pack_t;

endpackage

// ----- design/signed_int_to_decimal_ascii.sv -----
// Top level: 32-bit signed integer to decimal ASCII text stream.
// The first character leaves after the 32-step bit-serial BCD conversion,
//   the handoff to the emitter and the leading-zero drop.
// A new input is taken once the BCD converter has done its 32 single-bit
//   shift steps and handed its result on; up to 11 characters, one per
//   cycle unless stalled, stream out while the next number is converted.
// Reset: aresetn synchronous, active low; clears all handshake and FSM state.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input stream: tdata[31:0] = value (two's complement)
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sitd_pkg::VALUE_W-1:0] s_tdata,
    // result stream: tdata[7:0] = char_code, tlast = is_last
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sitd_pkg::CHAR_W-1:0]  m_tdata,
    output logic                         m_tlast
);
    import sitd_pkg::*;

    logic               in_xfer;
    logic               negative;
    logic [VALUE_W-1:0] magnitude;
    logic               dab_idle;
    logic               num_valid;
    logic               num_ready;
    bcd_pack_t          num;

    assign in_xfer = s_tvalid && s_tready;

    // Magnitude in unsigned arithmetic: the most negative value maps to 2^31.
    assign negative  = s_tdata[VALUE_W-1];
    assign magnitude = negative ? (VALUE_W'(0) - s_tdata) : s_tdata;

    // One number in conversion at a time; the emitter drains the previous one.
    assign s_tready = dab_idle;

    sitd_dabble u_dabble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (in_xfer),
        .negative  (negative),
        .magnitude (magnitude),
        .idle      (dab_idle),
        .res_valid (num_valid),
        .res_ready (num_ready),
        .res       (num)
    );

    // Output register inside the emitter holds a stalled character.
    sitd_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (num_valid),
        .in_ready (num_ready),
        .in_num   (num),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- design/sitd_dabble.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
`timescale 1ns / 1ps

module sitd_dabble (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        negative,
    input  logic [sitd_pkg::VALUE_W-1:0] magnitude,
    output logic                        idle,
    output logic                        res_valid,
    input  logic                        res_ready,
    output sitd_pkg::bcd_pack_t         res
);
    import sitd_pkg::*;

    typedef enum logic [1:0] {
        D_IDLE,
        D_SHIFT,
        D_HOLD
    } dab_state_t;

    localparam int CNT_W = $clog2(VALUE_W);

    dab_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               neg_reg, neg_next;
    logic [BCD_W-1:0]   bcd_adj;

    // Add 3 to every digit of 5 or more before the shift.
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        case (state_reg)
            D_IDLE: begin
                if (start) begin
                    bin_next   = magnitude;
                    bcd_next   = '0;
                    neg_next   = negative;
                    cnt_next   = '0;
                    state_next = D_SHIFT;
                end
            end
            D_SHIFT: begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W - 1)) begin
                    state_next = D_HOLD;
                end
            end
            D_HOLD: begin
                if (res_ready) begin
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign idle         = (state_reg == D_IDLE);
    assign res_valid    = (state_reg == D_HOLD);
    assign res.negative = neg_reg;
    assign res.bcd      = bcd_reg;

endmodule

// ----- design/sitd_emit.sv -----
// Character emitter: drops leading zeros, sends sign and digits one per transfer.
`timescale 1ns / 1ps

module sitd_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sitd_pkg::bcd_pack_t         in_num,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sitd_pkg::CHAR_W-1:0] m_tdata,
    output logic                        m_tlast
);
    import sitd_pkg::*;

    typedef enum logic [1:0] {
        E_IDLE,
        E_SKIP,
        E_EMIT
    } emit_state_t;

    localparam int CNT_W = $clog2(BCD_DIGITS + 1);

    emit_state_t        state_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               sign_reg;
    logic               valid_reg;
    logic [CHAR_W-1:0]  data_reg;
    logic               last_reg;
    logic               slot_free;
    logic               load_char;
    logic [3:0]         top_digit;

    assign slot_free = !valid_reg || m_tready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    // a new character enters the output register this cycle
    assign load_char = slot_free &&
                       (((state_reg == E_SKIP) && sign_reg) || (state_reg == E_EMIT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            valid_reg <= 1'b0;
            sign_reg  <= 1'b0;
        end else begin
            if (slot_free) begin
                valid_reg <= load_char;
            end
            case (state_reg)
                E_IDLE: begin
                    if (in_valid) begin
                        bcd_reg   <= in_num.bcd;
                        sign_reg  <= in_num.negative;
                        cnt_reg   <= CNT_W'(BCD_DIGITS);
                        state_reg <= E_SKIP;
                    end
                end
                E_SKIP: begin
                    // sign may go out while leading zeros are dropped
                    if (sign_reg && slot_free) begin
                        data_reg  <= ASCII_MINUS;
                        last_reg  <= 1'b0;
                        sign_reg  <= 1'b0;
                    end
                    if (top_digit == 4'd0 && cnt_reg > CNT_W'(1)) begin
                        bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
                        cnt_reg <= cnt_reg - 1'b1;
                    end else begin
                        state_reg <= E_EMIT;
                    end
                end
                E_EMIT: begin
                    if (slot_free) begin
                        if (sign_reg) begin
                            data_reg <= ASCII_MINUS;
                            last_reg <= 1'b0;
                            sign_reg <= 1'b0;
                        end else begin
                            data_reg <= ASCII_ZERO | {4'd0, top_digit};
                            last_reg <= (cnt_reg == CNT_W'(1));
                            bcd_reg  <= {bcd_reg[BCD_W-5:0], 4'd0};
                            cnt_reg  <= cnt_reg - 1'b1;
                            if (cnt_reg == CNT_W'(1)) begin
                                state_reg <= E_IDLE;
                            end
                        end
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == E_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- design/sitd_checker.sv -----
// Port-level checker for the decimal text converter, bound to the top level.
`timescale 1ns / 1ps

module sitd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [sitd_pkg::VALUE_W-1:0] s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [sitd_pkg::CHAR_W-1:0]  m_tdata,
    input logic                         m_tlast
);
    import sitd_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // only sign or digit characters
    a_chars: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == ASCII_MINUS) ||
                     ((m_tdata >= ASCII_ZERO) && (m_tdata <= ASCII_NINE)))
        else $error("illegal character code");

    // the sign never ends a number
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata == ASCII_MINUS) |-> !m_tlast)
        else $error("minus sign flagged as last");

    // converter is busy right after taking a number
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted during conversion");

    // nothing valid leaves right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps

module tb;
    import sitd_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int IDLE_LIMIT     = 2000;  // cycles with no transfer on either side
    localparam int RX_HOLD_CYCLES = 400;   // long receiver back-pressure stretch
    localparam int DRAIN_CYCLES   = 60;    // beyond the worst first-character latency

    // One expected output character.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    // Turns each accepted integer into its expected character stream and
    // checks the characters that come out against it, oldest first.
    class text_scoreboard;
        text_char_t exp_text[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        task report_mismatch(input string what);
            errors++;
            $display("%0t ns  mismatch: %s", $time, what);
        endtask

        function void note_value(input logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] mag;
            logic [3:0]         digit [BCD_DIGITS];
            int                 ndig;
            text_char_t         ch;
            ndig = 0;
            // two's complement negate in 32 bits; the most negative value
            // stays 0x80000000, which is its correct magnitude unsigned
            mag  = value[VALUE_W-1] ? (32'd0 - value) : value;
            do begin
                digit[ndig] = 4'(mag % 10);
                mag         = mag / 10;
                ndig++;
            end while (mag != 0 && ndig < BCD_DIGITS);
            if (value[VALUE_W-1]) begin
                ch.code = ASCII_MINUS;
                ch.last = 1'b0;
                exp_text.push_back(ch);
            end
            for (int i = ndig - 1; i >= 0; i--) begin
                ch.code = ASCII_ZERO + CHAR_W'(digit[i]);
                ch.last = (i == 0);
                exp_text.push_back(ch);
            end
        endfunction

        task check_char(input logic [CHAR_W-1:0] code, input logic last);
            text_char_t want;
            if (exp_text.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h last=%0b", code, last));
            end else begin
                want = exp_text.pop_front();
                if (code !== want.code)
                    report_mismatch($sformatf("char 0x%02h, want 0x%02h", code, want.code));
                if (last !== want.last)
                    report_mismatch($sformatf("tlast %0b, want %0b on char 0x%02h",
                                              last, want.last, want.code));
            end
        endtask

        function int pending();
            return exp_text.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CHAR_W-1:0]    m_tdata;
    logic                 m_tlast;

    // traffic shaping, set by the stimulus thread
    logic tx_idle_en  = 1'b0;
    logic rx_idle_en  = 1'b0;
    logic rx_hold_req = 1'b0;

    int             idle_cycles = 0;
    text_scoreboard sb;

    signed_int_to_decimal_ascii i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [31:0] value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // [7:0] char_code
        .m_tlast  (m_tlast)      // is_last
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random value: mix of chosen digit counts, raw 32-bit patterns and
    // values around powers of ten (where the digit count changes).
    function automatic logic [VALUE_W-1:0] rand_value();
        longint lo, hi, mag, p;
        int     ndig;
        logic   neg;
        int     pick;
        pick = $urandom_range(0, 9);
        neg  = 1'($urandom_range(0, 1));
        if (pick < 5) begin
            ndig = $urandom_range(1, 10);
            lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
            hi   = 10 ** ndig - 1;
            if (hi > 64'sd2147483647) hi = neg ? 64'sd2147483648 : 64'sd2147483647;
            mag  = lo + longint'($urandom) % (hi - lo + 1);
        end else if (pick < 8) begin
            return $urandom;
        end else begin
            p   = 10 ** $urandom_range(0, 9);
            mag = p + $urandom_range(0, 2) - 1;
        end
        return neg ? VALUE_W'(-mag) : VALUE_W'(mag);
    endfunction

    // Offer one value and hold it until the transfer happens.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        if (tx_idle_en && $urandom_range(0, 2) == 0) begin
            gap = gap_len();
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_value(rand_value());
    endtask

    // Receiver: random back-pressure, plus one long hold on request.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Transfer monitor: values and outputs as seen at the accepting edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_value(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_char(m_tdata, m_tlast);
        end
    end

    // Watchdog: any transfer restarts the count.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero, single digits, digit-count boundaries, both extremes
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'd99);
        send_value(32'd100);
        send_value(32'h7FFF_FFFF);          // largest positive
        send_value(32'h8000_0000);          // most negative, eleven characters
        send_value(32'h8000_0001);
        send_value(32'd999999999);
        send_value(32'd1000000000);
        send_value(-32'sd999999999);
        send_value(-32'sd1000000000);
        send_value(32'd1234567890);
        send_value(32'd2147483646);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);

        // random with idling on both sides
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_random(60);

        // receiver holds off while the sender keeps offering back to back
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        send_random(20);

        // sender pauses until the pipeline is empty; waiting on a clock edge first
        // lets the monitor note the last accepted value
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);

        // full rate, no idling
        send_random(60);

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_random(55);
        s_tvalid <= 1'b0;
        @(posedge aclk);

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
